// File: hdl/tbeip_pkg.sv
// Package for the trace begin/end interval pairing unit.
// Shared sizes, status codes and the state type; no dependencies.
package tbeip_pkg;

	localparam int MAX_THREADS = 8;
	localparam int STACK_DEPTH = 8;
	localparam int TIDX_W = $clog2(MAX_THREADS);
	localparam int DIDX_W = $clog2(STACK_DEPTH);
	localparam int ENTRIES = MAX_THREADS * STACK_DEPTH;
	localparam int ADDR_W = TIDX_W + DIDX_W;
	localparam int CNT_W = $clog2(MAX_THREADS + 1);
	localparam int FILL_W = $clog2(STACK_DEPTH + 1);
	localparam logic [19:0] US_PER_SEC = 20'd1000000;
	localparam logic [31:0] TICK_FREQ_RST = 32'd1000000;

	localparam logic [1:0] ST_CLOSED = 2'd0;
	localparam logic [1:0] ST_FLUSHED = 2'd1;
	localparam logic [1:0] ST_DROPPED = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	localparam logic REG_TICK_FREQ = 1'b0;
	localparam logic REG_QUANT_SHIFT = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_EVENT,
		S_POPRD,
		S_POP,
		S_FLSCAN,
		S_FLRD,
		S_FLOUT,
		S_FLEND,
		S_OUT
	} state_t;

	typedef struct packed {
		logic          wr;
		logic [ADDR_W-1:0] addr;
		logic [15:0]   region;
		logic [31:0]   start;
	} mem_req_t;

endpackage

// File: hdl/trace_begin_end_interval_pairing_unit.sv
// Top level of the trace begin/end interval pairing unit.
// Uses tbeip_pkg, tbeip_divider and tbeip_stack_mem.
//
// The unit takes one transaction at a time and is ready again in the cycle after
// the previous one is done. A begin event is captured on acceptance, then its
// timestamp is scaled, divided by the bit-serial 64-by-32 divider and written
// to the stack. An end event that closes an interval adds a memory read, a
// compare and the hand-off to the output register. A dropped event from an
// unknown thread on a full map skips the divider. A flush walks the threads in
// index order and each one's open stack entries top down, reading each emitted
// interval through the stack memory. Stack entries live in a synchronous memory;
// the thread map, fills and time bounds are registers. A result is staged and
// then moves to the output register once that register is free, so a new
// transaction is accepted while a result waits; the unit stalls only when its
// next result is ready before the previous one has been taken.
module trace_begin_end_interval_pairing_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// s_tdata, low to high: opcode, phase, thread_id, event_id, raw_time, end_time
	input  logic [151:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// m_tdata, low to high: status, thread_index, region_id, start_us,
	// duration_us, nest_depth, thread_count, min_time, max_time (pad to 192)
	output logic [191:0] m_tdata,
	output logic         m_tlast,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data
);
	import tbeip_pkg::*;

	state_t state_q, state_d;

	logic [31:0] tick_freq_q;
	logic [4:0]  quant_shift_q;
	logic [31:0] keys_q [MAX_THREADS];
	logic [CNT_W-1:0]  mapped_q;
	logic [FILL_W-1:0] fill_q [MAX_THREADS];
	logic [31:0] tlow_q, thigh_q;
	logic        seen_q;

	// Captured transaction.
	logic        opcode_q, phase_q;
	logic [31:0] tid_q, endt_q;
	logic [15:0] eid_q;
	logic [63:0] raw_q;
	logic [TIDX_W-1:0] idx_q;
	logic [31:0] ts_q;
	logic [TIDX_W-1:0] ft_q;
	logic [FILL_W-1:0] fd_q;
	logic        any_out_q;

	// Staged result and the output register.
	logic [191:0] res_q;
	logic [191:0] out_q;
	logic         out_v_q, out_last_q;

	logic [31:0] tid_in;
	logic [TIDX_W-1:0] hit_idx;
	logic        hit;
	logic [63:0] shifted, scaled;
	logic        div_start, div_done;
	logic [31:0] quotient;
	mem_req_t    req;
	logic [15:0] rd_region;
	logic [31:0] rd_start;
	logic        out_free, out_load, fl_last;

	assign tid_in = s_tdata[33:2];
	assign s_tready = (state_q == S_IDLE);

	// The output register can take a new result when it is empty or being read.
	assign out_free = !out_v_q || m_tready;
	assign out_load = out_free && (state_q == S_OUT || state_q == S_FLOUT ||
		(state_q == S_FLEND && !any_out_q));

	// Thread lookup on the captured id.
	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		for (int i = 0; i < MAX_THREADS; i++) begin
			if (!hit && (i < mapped_q) && keys_q[i] == tid_q) begin
				hit = 1'b1;
				hit_idx = TIDX_W'(i);
			end
		end
	end

	// During a flush, the current entry is the final one when it is the bottom
	// of its stack and no later thread has anything open.
	always_comb begin
		fl_last = (fd_q == FILL_W'(1));
		for (int t = 0; t < MAX_THREADS; t++) begin
			if (t > int'(ft_q) && fill_q[t] != '0) fl_last = 1'b0;
		end
	end

	// Shifted timestamp times one million, modulo 2^64, as a sum of shifts:
	// 1000000 = 2^20 - 2^16 + 2^14 + 2^9 + 2^6.
	always_comb begin
		shifted = raw_q << quant_shift_q;
		scaled = (shifted << 20) - (shifted << 16) + (shifted << 14) +
			(shifted << 9) + (shifted << 6);
	end

	tbeip_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(scaled),
		.divisor(tick_freq_q), .done(div_done), .quotient(quotient)
	);

	tbeip_stack_mem u_mem (
		.clk(clk), .req(req), .rd_region(rd_region), .rd_start(rd_start)
	);

	assign div_start = (state_q == S_MUL) && opcode_q == 1'b0;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (s_tvalid) state_d = S_MUL;
			S_MUL: begin
				if (opcode_q) state_d = S_FLSCAN;
				else if (!hit && mapped_q >= CNT_W'(MAX_THREADS)) state_d = S_OUT;
				else state_d = S_DIV;
			end
			S_DIV: if (div_done) state_d = S_EVENT;
			S_EVENT: begin
				if (phase_q && fill_q[idx_q] != '0) state_d = S_POPRD;
				else state_d = S_IDLE;
			end
			S_POPRD: state_d = S_POP;
			S_POP: state_d = (rd_region == eid_q) ? S_OUT : S_IDLE;
			S_FLSCAN: begin
				if (fd_q != '0) state_d = S_FLRD;
				else if (ft_q == TIDX_W'(MAX_THREADS - 1)) state_d = S_FLEND;
			end
			S_FLRD: state_d = S_FLOUT;
			S_FLOUT: begin
				if (out_free) begin
					if (fl_last) state_d = S_FLEND;
					else if (fd_q != FILL_W'(1)) state_d = S_FLRD;
					else state_d = S_FLSCAN;
				end
			end
			S_FLEND: if (any_out_q || out_free) state_d = S_IDLE;
			S_OUT: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Memory request. The flush keeps its read address while the output stalls,
	// so the read data stays valid.
	always_comb begin
		req = '0;
		unique case (state_q)
			S_EVENT: begin
				req.wr = !phase_q && fill_q[idx_q] < FILL_W'(STACK_DEPTH);
				req.addr = {idx_q, DIDX_W'(fill_q[idx_q])};
				req.region = eid_q;
				req.start = ts_q;
			end
			S_POPRD: req.addr = {idx_q, DIDX_W'(fill_q[idx_q] - FILL_W'(1))};
			S_FLRD, S_FLOUT: req.addr = {ft_q, DIDX_W'(fd_q - FILL_W'(1))};
			default: req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tick_freq_q <= TICK_FREQ_RST;
			quant_shift_q <= '0;
			mapped_q <= '0;
			for (int i = 0; i < MAX_THREADS; i++) fill_q[i] <= '0;
			tlow_q <= '0;
			thigh_q <= '0;
			seen_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == REG_TICK_FREQ) tick_freq_q <= cfg_data;
				else quant_shift_q <= cfg_data[4:0];
			end
			out_v_q <= out_load || (out_v_q && !m_tready);
			unique case (state_q)
				S_MUL: begin
					if (!opcode_q && !hit && mapped_q < CNT_W'(MAX_THREADS))
						mapped_q <= mapped_q + CNT_W'(1);
				end
				S_EVENT: begin
					if (!seen_q || ts_q < tlow_q) tlow_q <= ts_q;
					if (!seen_q || ts_q > thigh_q) thigh_q <= ts_q;
					seen_q <= 1'b1;
					if (!phase_q && fill_q[idx_q] < FILL_W'(STACK_DEPTH))
						fill_q[idx_q] <= fill_q[idx_q] + FILL_W'(1);
				end
				S_POP: if (rd_region == eid_q) fill_q[idx_q] <= fill_q[idx_q] - FILL_W'(1);
				// The flush ends by clearing the thread map, the stacks and the bounds.
				S_FLEND: if (any_out_q || out_free) begin
					mapped_q <= '0;
					for (int i = 0; i < MAX_THREADS; i++) fill_q[i] <= '0;
					seen_q <= 1'b0;
					tlow_q <= '0;
					thigh_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				opcode_q <= s_tdata[0];
				phase_q <= s_tdata[1];
				tid_q <= tid_in;
				eid_q <= s_tdata[49:34];
				raw_q <= s_tdata[113:50];
				endt_q <= s_tdata[145:114];
				ft_q <= '0;
				any_out_q <= 1'b0;
			end
			S_MUL: begin
				idx_q <= hit ? hit_idx : TIDX_W'(mapped_q);
				if (!hit && mapped_q < CNT_W'(MAX_THREADS))
					keys_q[TIDX_W'(mapped_q)] <= tid_q;
				fd_q <= fill_q[0];
				res_q <= {36'd0, 32'd0, 32'd0, 4'd0, 3'd0, 32'd0, 32'd0,
					eid_q, 3'd0, ST_DROPPED};
			end
			S_DIV: if (div_done) ts_q <= quotient;
			S_POP: res_q <= {36'd0, 32'd0, 32'd0, 4'd0, DIDX_W'(fill_q[idx_q] - FILL_W'(1)),
				ts_q - rd_start, rd_start, rd_region, idx_q, ST_CLOSED};
			S_FLSCAN: if (fd_q == '0 && ft_q != TIDX_W'(MAX_THREADS - 1)) begin
				ft_q <= ft_q + TIDX_W'(1);
				fd_q <= fill_q[ft_q + TIDX_W'(1)];
			end
			S_FLOUT: if (out_free) begin
				any_out_q <= 1'b1;
				out_last_q <= fl_last;
				out_q <= {36'd0, seen_q ? thigh_q : 32'd0, seen_q ? tlow_q : 32'd0,
					mapped_q, DIDX_W'(fd_q - FILL_W'(1)), endt_q - rd_start,
					rd_start, rd_region, ft_q, ST_FLUSHED};
				if (fd_q == FILL_W'(1) && ft_q != TIDX_W'(MAX_THREADS - 1)) begin
					ft_q <= ft_q + TIDX_W'(1);
					fd_q <= fill_q[ft_q + TIDX_W'(1)];
				end else begin
					fd_q <= fd_q - FILL_W'(1);
				end
			end
			S_FLEND: if (!any_out_q && out_free) begin
				out_last_q <= 1'b1;
				out_q <= {36'd0, seen_q ? thigh_q : 32'd0, seen_q ? tlow_q : 32'd0,
					mapped_q, 3'd0, 32'd0, 32'd0, 16'd0, 3'd0, ST_EMPTY};
			end
			S_OUT: if (out_free) begin
				out_last_q <= 1'b1;
				out_q <= res_q;
			end
			default: ;
		endcase
	end

	// A flush marks its final interval with tlast; an empty flush sends the
	// nothing-open item instead.
	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;
	assign m_tlast = out_last_q;

endmodule

// File: hdl/tbeip_stack_mem.sv
// Stack entry memory: region id and start time of open intervals.
// Uses tbeip_pkg; one read per cycle plus an optional write, read data registered.
module tbeip_stack_mem (
	input  logic                clk,
	input  tbeip_pkg::mem_req_t req,
	output logic [15:0]         rd_region,
	output logic [31:0]         rd_start
);
	import tbeip_pkg::*;

	logic [47:0] mem_q [ENTRIES];

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem_q[req.addr] <= {req.region, req.start};
		end
		{rd_region, rd_start} <= mem_q[req.addr];
	end

endmodule

// File: hdl/tbeip_divider.sv
// Iterative 64-by-32 divider, one quotient bit per cycle.
// Uses tbeip_pkg; yields the low 32 quotient bits, all ones for zero divisor.
module tbeip_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	import tbeip_pkg::*;

	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] div_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;
	logic [33:0] diff;

	always_comb begin
		trial = {rem_q[31:0], quo_q[63]};
		diff = {1'b0, trial} - {2'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!diff[33]) begin
				rem_q <= diff[32:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign quotient = (div_q == 32'd0) ? 32'hFFFF_FFFF : quo_q[31:0];

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for trace_begin_end_interval_pairing_unit.
// Depends on tbeip_pkg; drives a directed table and random traffic against an in-bench predictor.
`timescale 1ns / 1ps

module tb_top;
	import tbeip_pkg::*;

	typedef struct {
		logic        opcode;
		logic        phase;
		logic [31:0] thread_id;
		logic [15:0] event_id;
		logic [63:0] raw_time;
		logic [31:0] end_time;
	} trace_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  thread_index;
		logic [15:0] region_id;
		logic [31:0] start_us;
		logic [31:0] duration_us;
		logic [2:0]  nest_depth;
		logic [3:0]  thread_count;
		logic [31:0] min_time;
		logic [31:0] max_time;
		logic        last;
	} interval_t;

	// One row of the directed table; a typed expectation replaces the predicted one.
	typedef struct {
		trace_item_t item;
		bit          typed;
		interval_t   exp;
	} stim_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [151:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [191:0] m_tdata;
	logic         m_tlast;
	logic         cfg_we;
	logic         cfg_index;
	logic [31:0]  cfg_data;

	trace_begin_end_interval_pairing_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Shadow copy of the unit's state and registers.
	logic [31:0] tick_freq;
	logic [4:0]  quant_shift;
	logic [31:0] thread_keys [MAX_THREADS];
	int          threads_mapped;
	int          stack_fill [MAX_THREADS];
	logic [15:0] stack_region [ENTRIES];
	logic [31:0] stack_start [ENTRIES];
	logic [31:0] time_low, time_high;
	bit          any_seen;

	interval_t   interval_q [$];
	int          mismatches;
	int          sender_idle_pct, receiver_stall_pct;
	int          hold_off_cycles;
	int          quiet_cycles;
	logic [31:0] tid_pool [12];

	function automatic void clear_shadow();
		threads_mapped = 0;
		any_seen = 0;
		time_low = '0;
		time_high = '0;
		for (int t = 0; t < MAX_THREADS; t++) stack_fill[t] = 0;
	endfunction

	function automatic logic [31:0] to_micro(logic [63:0] raw);
		logic [63:0] scaled;
		scaled = (raw << quant_shift) * 64'(US_PER_SEC);
		if (tick_freq == 0) return 32'hFFFF_FFFF;
		return 32'(scaled / {32'd0, tick_freq});
	endfunction

	function automatic interval_t mk(logic [1:0] st, int tidx, logic [15:0] rid,
			logic [31:0] st_us, logic [31:0] dur, int depth, int cnt,
			logic [31:0] lo, logic [31:0] hi, logic lst);
		interval_t r;
		r.status = st; r.thread_index = 3'(tidx); r.region_id = rid;
		r.start_us = st_us; r.duration_us = dur; r.nest_depth = 3'(depth);
		r.thread_count = 4'(cnt); r.min_time = lo; r.max_time = hi; r.last = lst;
		return r;
	endfunction

	// Updates the shadow state for one accepted transaction and, if asked,
	// queues the intervals that it closes.
	function automatic void pair_events(trace_item_t it, bit queue_results);
		interval_t res [$];
		int idx;
		bit found;
		logic [31:0] ts, lo, hi;
		int e;
		found = 0;
		idx = 0;
		if (it.opcode) begin
			lo = any_seen ? time_low : 32'd0;
			hi = any_seen ? time_high : 32'd0;
			// Flush closes threads in index order, each from the top of its stack down.
			for (int t = 0; t < MAX_THREADS; t++) begin
				for (int d = stack_fill[t]; d > 0; d--) begin
					e = t * STACK_DEPTH + d - 1;
					res = {res, mk(ST_FLUSHED, t, stack_region[e], stack_start[e],
						it.end_time - stack_start[e], d - 1, threads_mapped, lo, hi, 0)};
				end
			end
			if (res.size() == 0)
				res = {res, mk(ST_EMPTY, 0, 0, 0, 0, 0, threads_mapped, lo, hi, 1)};
			else
				res[res.size()-1].last = 1;
			clear_shadow();
		end else begin
			for (int i = 0; i < threads_mapped; i++) begin
				if (!found && thread_keys[i] == it.thread_id) begin
					found = 1;
					idx = i;
				end
			end
			if (!found && threads_mapped >= MAX_THREADS) begin
				res = {res, mk(ST_DROPPED, 0, it.event_id, 0, 0, 0, 0, 0, 0, 1)};
			end else begin
				if (!found) begin
					idx = threads_mapped;
					thread_keys[idx] = it.thread_id;
					threads_mapped++;
				end
				ts = to_micro(it.raw_time);
				if (!any_seen) begin
					time_low = ts;
					time_high = ts;
					any_seen = 1;
				end else begin
					if (ts < time_low) time_low = ts;
					if (ts > time_high) time_high = ts;
				end
				if (it.phase == 1'b0) begin
					// A begin on a full stack is dropped silently.
					if (stack_fill[idx] < STACK_DEPTH) begin
						e = idx * STACK_DEPTH + stack_fill[idx];
						stack_region[e] = it.event_id;
						stack_start[e] = ts;
						stack_fill[idx]++;
					end
				end else if (stack_fill[idx] > 0) begin
					e = idx * STACK_DEPTH + stack_fill[idx] - 1;
					if (stack_region[e] == it.event_id) begin
						res = {res, mk(ST_CLOSED, idx, it.event_id, stack_start[e],
							ts - stack_start[e], stack_fill[idx] - 1, 0, 0, 0, 1)};
						stack_fill[idx]--;
					end
				end
			end
		end
		if (queue_results)
			foreach (res[i]) interval_q = {interval_q, res[i]};
	endfunction

	function automatic trace_item_t mk_item(logic op, logic ph, logic [31:0] tid,
			logic [15:0] eid, logic [63:0] raw, logic [31:0] et);
		trace_item_t it;
		it.opcode = op; it.phase = ph; it.thread_id = tid;
		it.event_id = eid; it.raw_time = raw; it.end_time = et;
		return it;
	endfunction

	// Offers one transaction, with random idle cycles ahead of it, and
	// updates the predictor once it is accepted. Valid is only lowered in the
	// idle loop, so back-to-back items keep it high.
	task automatic send(trace_item_t it, bit queue_results);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, it.end_time, it.raw_time, it.event_id, it.thread_id,
			it.phase, it.opcode};
		do @(posedge clk); while (!s_tready);
		pair_events(it, queue_results);
	endtask

	// Registers change only once the unit has drained; begins leave no
	// result, so the task keeps waiting after the last result has been taken.
	task automatic write_reg(logic idx, logic [31:0] value);
		s_tvalid <= 1'b0;
		while (interval_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_TICK_FREQ) tick_freq = value;
		else quant_shift = value[4:0];
	endtask

	function automatic trace_item_t random_item();
		trace_item_t it;
		int t, top;
		it.opcode = ($urandom_range(0, 29) == 0);
		it.thread_id = tid_pool[($urandom_range(0, 19) == 0) ?
			$urandom_range(8, 11) : $urandom_range(0, 7)];
		it.phase = $urandom_range(0, 99) < 50;
		it.event_id = 16'($urandom);
		it.raw_time = $urandom_range(0, 1) ? {$urandom, $urandom} :
			64'($urandom_range(0, 2000000));
		it.end_time = $urandom;
		// Most ends name the open region of their thread so that intervals close.
		if (it.phase) begin
			for (t = 0; t < threads_mapped; t++) begin
				if (thread_keys[t] == it.thread_id && stack_fill[t] > 0 &&
						$urandom_range(0, 99) < 80) begin
					top = t * STACK_DEPTH + stack_fill[t] - 1;
					it.event_id = stack_region[top];
				end
			end
		end
		return it;
	endfunction

	// Result side: random stalls, plus a long hold-off when one is requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_off_cycles > 0) begin
			m_tready <= 1'b0;
			hold_off_cycles <= hold_off_cycles - 1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
		end
	end

	// Compares each accepted result with the oldest outstanding expectation.
	always @(posedge clk) begin
		interval_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = mk(m_tdata[1:0], m_tdata[4:2], m_tdata[20:5], m_tdata[52:21],
				m_tdata[84:53], m_tdata[87:85], m_tdata[91:88], m_tdata[123:92],
				m_tdata[155:124], m_tlast);
			if (interval_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", got);
			end else begin
				want = interval_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, actual %p", want, got);
				end
			end
		end
	end

	// Watchdog: ends the run if no transaction moves for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 20000) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		stim_row_t rows [$];
		stim_row_t row;
		mismatches = 0;
		quiet_cycles = 0;
		hold_off_cycles = 0;
		sender_idle_pct = 8;
		receiver_stall_pct = 72;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = REG_TICK_FREQ;
		cfg_data = '0;
		arst_n = 1'b0;
		tick_freq = TICK_FREQ_RST;
		quant_shift = '0;
		clear_shadow();
		foreach (tid_pool[i]) tid_pool[i] = $urandom;
		tid_pool[0] = 32'd0;
		tid_pool[1] = 32'hFFFF_FFFF;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Flush right after reset: nothing open, nothing seen.
		row.typed = 1;
		row.item = mk_item(1, 0, 0, 0, 0, 0);
		row.exp = mk(ST_EMPTY, 0, 0, 0, 0, 0, 0, 0, 0, 1);
		rows = {rows, row};
		row.typed = 0;
		row.item = mk_item(0, 0, 0, 16'h0005, 64'd0, 0); rows = {rows, row};
		row.item = mk_item(0, 0, 0, 16'hFFFF, '1, 0); rows = {rows, row};
		row.item = mk_item(0, 1, 0, 16'h0001, 64'd7, 0); rows = {rows, row};    // wrong region
		row.item = mk_item(0, 1, 0, 16'hFFFF, 64'd1, 0); rows = {rows, row};    // wraps duration
		row.item = mk_item(0, 1, 0, 16'h0005, 64'd3000000, 0); rows = {rows, row};
		row.item = mk_item(0, 1, 0, 16'h0005, 64'd9, 0); rows = {rows, row};    // empty stack
		// Nine begins on one thread: the last finds the stack full.
		for (int i = 0; i < 9; i++) begin
			row.item = mk_item(0, 0, 32'hFFFF_FFFF, 16'(i + 16'h100), 64'(i * 50), 0);
			rows = {rows, row};
		end
		row.item = mk_item(0, 1, 32'hFFFF_FFFF, 16'h0107, 64'd999, 0); rows = {rows, row};
		for (int t = 2; t < MAX_THREADS; t++) begin
			row.item = mk_item(0, 0, 32'(t * 32'h1111_1111), 16'(t), 64'(t), 0);
			rows = {rows, row};
		end
		// A ninth distinct thread no longer fits in the map.
		row.typed = 1;
		row.item = mk_item(0, 0, 32'h5555_AAAA, 16'hBEEF, 64'd1, 0);
		row.exp = mk(ST_DROPPED, 0, 16'hBEEF, 0, 0, 0, 0, 0, 0, 1);
		rows = {rows, row};
		row.typed = 0;
		row.item = mk_item(1, 1, 32'hFFFF_FFFF, 16'hFFFF, '1, 32'hFFFF_FFFF);
		rows = {rows, row};
		foreach (rows[i]) begin
			send(rows[i].item, !rows[i].typed);
			if (rows[i].typed) interval_q = {interval_q, rows[i].exp};
		end

		// Zero divisor saturates every converted time.
		write_reg(REG_TICK_FREQ, 32'd0);
		send(mk_item(0, 0, 32'd42, 16'd1, 64'd5, 0), 1);
		send(mk_item(0, 1, 32'd42, 16'd1, 64'd6, 0), 1);
		send(mk_item(1, 0, 0, 0, 0, 32'd0), 1);

		// Three random phases with different registers and idling patterns.
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_TICK_FREQ, TICK_FREQ_RST);
					write_reg(REG_QUANT_SHIFT, 5'd0);
				end
				1: begin
					sender_idle_pct = 72;
					receiver_stall_pct = 8;
					write_reg(REG_TICK_FREQ, 32'd1);
					write_reg(REG_QUANT_SHIFT, 5'd31);
				end
				default: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
					write_reg(REG_TICK_FREQ, 32'hFFFF_FFFF);
					write_reg(REG_QUANT_SHIFT, 5'd7);
					// Long receiver hold-off while items keep coming.
					hold_off_cycles = 600;
				end
			endcase
			for (int n = 0; n < 127; n++) send(random_item(), 1);
			// Close whatever is open so each phase ends with a flush.
			send(mk_item(1, 0, 0, 0, 0, $urandom), 1);
		end

		s_tvalid <= 1'b0;
		while (interval_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && interval_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
